@@ rtl/bs_pkg.sv @@
// bs_pkg: sizes and shared types for the bubble sorter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package bs_pkg;

    localparam int DATA_W       = 32;
    localparam int MAX_ELEMENTS = 16;
    localparam int ADDR_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // command from front to back
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     store;  // value goes into the element store
        logic                     last;   // set ends here, sort and emit
        logic                     ovf;    // set dropped items (valid with last)
        logic                     desc;   // order in force (valid with last)
    } t_cmd;

endpackage

`default_nettype wire

@@ rtl/bubble_sorter.sv @@
// bubble_sorter: top level, front end, command queue and sort back end
// depends on bs_pkg, bs_front, bs_queue, bs_back
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input: an item (i_value, i_last_in) is taken at a clock edge with start high
//   and busy low. items of a set are stored; the one with i_last_in high ends
//   the set. once MAX_ELEMENTS values are held, further values of the set are
//   dropped and the whole set's results carry o_overflowed.
//   config: i_cfg_data picks the order (0 ascending, 1 descending), written on
//   i_cfg_valid with o_cfg_ready (always high); the value held when the last
//   item of a set is taken applies to that set. write it only while idle.
//   results: one per stored value, in order, each on o_sorted_value for one
//   cycle with o_result_valid; o_last_out marks the final one. the receiver
//   cannot stall, so results leave at one per cycle.
//   timing: items load at one per cycle through a two-deep queue; busy rises
//   when that queue is full, e.g. while the back end sorts or emits.
//   after the last item of a set, the sequencer runs compare passes, one compare
//   per cycle on the single store read port, then emits the results.
//   reset: synchronous, active low; clears set count, overflow, order (ascending)
//   and the queue. the element store holds no reset value.

module bubble_sorter (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic signed [bs_pkg::DATA_W-1:0] i_value,
    input  wire logic                             i_last_in,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic                             i_cfg_data,
    output logic                                  o_result_valid,
    output logic signed [bs_pkg::DATA_W-1:0]      o_sorted_value,
    output logic                                  o_last_out,
    output logic                                  o_overflowed
);
    import bs_pkg::*;

    // front to queue
    logic push;
    t_cmd push_cmd;
    logic q_full;
    // queue to back
    logic pop;
    t_cmd pop_cmd;
    logic q_empty;

    // front: accepts items, decides store or drop, ends sets
    bs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .i_last_in   (i_last_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // decouples item intake from the sort sequencer
    bs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (q_empty)
    );

    // back: fills the store, runs bubble passes, streams the results
    bs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_cmd          (pop_cmd),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflowed   (o_overflowed)
    );

endmodule

`default_nettype wire

@@ rtl/bs_front.sv @@
// bs_front: takes items, tracks set fill and overflow, issues commands
// depends on bs_pkg
`timescale 1ns / 1ps
`default_nettype none

module bs_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [bs_pkg::DATA_W-1:0] i_value,
    input  wire logic                         i_last_in,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic                         i_cfg_data,
    input  wire logic                         i_q_full,
    output logic                              o_push,
    output bs_pkg::t_cmd                      o_cmd
);
    import bs_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic             r_desc;
    logic             accept;
    logic             fits;

    assign busy        = i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign fits        = r_cnt < CNT_W'(MAX_ELEMENTS);

    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (accept) begin
            if (i_last_in) begin
                n_cnt = '0;
                n_ovf = 1'b0;
            end else if (fits) begin
                n_cnt = r_cnt + CNT_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    // dropped items that do not end the set make no command
    assign o_push      = accept && (fits || i_last_in);
    assign o_cmd.value = i_value;
    assign o_cmd.store = fits;
    assign o_cmd.last  = i_last_in;
    assign o_cmd.ovf   = r_ovf || !fits;
    assign o_cmd.desc  = r_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            r_desc <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
            if (i_cfg_valid && o_cfg_ready) begin
                r_desc <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/bs_queue.sv @@
// bs_queue: short command queue between front and back
// depends on bs_pkg
`timescale 1ns / 1ps
`default_nettype none

module bs_queue (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  bs_pkg::t_cmd i_cmd,
    output logic        o_full,
    input  wire logic   i_pop,
    output bs_pkg::t_cmd o_cmd,
    output logic        o_empty
);
    import bs_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/bs_back.sv @@
// bs_back: element store, bubble sort sequencer and result emission
// depends on bs_pkg
`timescale 1ns / 1ps
`default_nettype none

module bs_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_empty,
    input  bs_pkg::t_cmd                  i_cmd,
    output logic                          o_pop,
    output logic                          o_result_valid,
    output logic signed [bs_pkg::DATA_W-1:0] o_sorted_value,
    output logic                          o_last_out,
    output logic                          o_overflowed
);
    import bs_pkg::*;

    typedef enum logic [5:0] {
        S_LOAD = 6'b000001,
        S_RD0  = 6'b000010,
        S_RD1  = 6'b000100,
        S_CMP  = 6'b001000,
        S_WB   = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    logic signed [DATA_W-1:0] r_mem [MAX_ELEMENTS];
    logic signed [DATA_W-1:0] r_rd_data;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [CNT_W-1:0]         r_n, n_n;
    logic [CNT_W-1:0]         r_len, n_len;
    logic [ADDR_W-1:0]        r_k, n_k;
    logic [ADDR_W-1:0]        r_e, n_e;
    logic signed [DATA_W-1:0] r_carry, n_carry;
    logic                     r_desc, n_desc;
    logic                     r_ovf, n_ovf;
    logic                     r_out_vld, n_out_vld;
    logic                     r_out_last, n_out_last;
    logic                     r_out_ovf, n_out_ovf;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]        rd_addr;
    logic [CNT_W-1:0]         cnt_new;
    logic                     swap;

    // strictly out of order only, so equal values keep their place
    assign swap = r_desc ? (r_carry < r_rd_data) : (r_carry > r_rd_data);
    assign cnt_new = r_cnt + CNT_W'(i_cmd.store);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_n        = r_n;
        n_len      = r_len;
        n_k        = r_k;
        n_e        = r_e;
        n_carry    = r_carry;
        n_desc     = r_desc;
        n_ovf      = r_ovf;
        n_out_vld  = 1'b0;
        n_out_last = 1'b0;
        n_out_ovf  = r_ovf;
        mem_we     = 1'b0;
        mem_waddr  = r_k;
        mem_wdata  = r_carry;
        rd_addr    = '0;
        o_pop      = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.store) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_cnt[ADDR_W-1:0];
                        mem_wdata = i_cmd.value;
                    end
                    if (i_cmd.last) begin
                        n_n     = cnt_new;
                        n_len   = cnt_new;
                        n_ovf   = i_cmd.ovf;
                        n_desc  = i_cmd.desc;
                        n_cnt   = '0;
                        n_e     = '0;
                        n_state = (cnt_new >= CNT_W'(2)) ? S_RD0 : S_EMIT;
                    end else begin
                        n_cnt = cnt_new;
                    end
                end
            end
            S_RD0: begin
                rd_addr = '0;
                n_state = S_RD1;
            end
            S_RD1: begin
                // element 0 becomes the bubble, element 1 is on its way
                rd_addr = ADDR_W'(1);
                n_carry = r_rd_data;
                n_k     = '0;
                n_state = S_CMP;
            end
            S_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = r_k;
                mem_wdata = swap ? r_rd_data : r_carry;
                n_carry   = swap ? r_carry : r_rd_data;
                rd_addr   = r_k + ADDR_W'(2);
                n_k       = r_k + ADDR_W'(1);
                if (CNT_W'(r_k) + CNT_W'(2) == r_len) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                // bubble settles at the end of this pass
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(r_len - CNT_W'(1));
                mem_wdata = r_carry;
                n_len     = r_len - CNT_W'(1);
                n_e       = '0;
                n_state   = (r_len > CNT_W'(2)) ? S_RD0 : S_EMIT;
            end
            S_EMIT: begin
                rd_addr    = r_e;
                n_out_vld  = 1'b1;
                n_out_last = (CNT_W'(r_e) + CNT_W'(1)) == r_n;
                n_e        = r_e + ADDR_W'(1);
                if (n_out_last) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_len      <= n_len;
        r_k        <= n_k;
        r_e        <= n_e;
        r_carry    <= n_carry;
        r_desc     <= n_desc;
        r_ovf      <= n_ovf;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_result_valid = r_out_vld;
    assign o_sorted_value = r_rd_data;
    assign o_last_out     = r_out_vld && r_out_last;
    assign o_overflowed   = r_out_vld && r_out_ovf;

`ifndef SYNTHESIS
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $past(r_state == S_EMIT))
        else $error("result without emit read");
    a_pop_only_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_LOAD) && !i_q_empty)
        else $error("queue popped outside load");
    a_cmp_pass_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_len >= CNT_W'(2)) && (CNT_W'(r_k) + CNT_W'(2) <= r_len))
        else $error("compare outside pass");
    a_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && o_pop && i_cmd.store) |-> (r_cnt < CNT_W'(MAX_ELEMENTS)))
        else $error("store beyond capacity");
    a_set_ends_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && n_out_last) |=> (r_state == S_LOAD) && r_out_vld)
        else $error("final result not followed by load");
`endif

endmodule

`default_nettype wire
